// File: sv/efr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escaped frame receiver package
// Shared constants, codes and the command record passed from parser to drain.
// ----------------------------------------------------------------------------
package efr_pkg;

    // Frame store geometry.
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    // Configuration register.
    localparam int LIMIT_W     = 7;
    localparam int LIMIT_RESET = 64;

    // Command queue between the parser and the drain engine.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Link control characters.
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ESC = 8'h18;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    // Error codes.
    typedef enum logic [1:0] {
        ERR_SOH      = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_ESC      = 2'd2
    } err_code_t;

    // Command operations.
    typedef enum logic [1:0] {
        CMD_STORE = 2'd0,
        CMD_ERROR = 2'd1,
        CMD_DRAIN = 2'd2
    } cmd_op_t;

    // One command: store data at address, report an error, or drain count bytes.
    typedef struct packed {
        cmd_op_t          op;
        logic [7:0]       data;
        logic [CNT_W-1:0] count;
        err_code_t        code;
    } cmd_t;

endpackage
`default_nettype wire

// File: sv/efr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escaped frame receiver parser
// Accepts received bytes, tracks the SOH/EOT/ESC mode and fill level, and
// turns each byte into at most one command for the drain engine.
// ----------------------------------------------------------------------------
module efr_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [7:0]                  rx_byte,
    input  wire logic                        cfg_wr,
    input  wire logic [efr_pkg::LIMIT_W-1:0] cfg_data,
    input  wire logic                        q_full,
    output logic                             q_push,
    output efr_pkg::cmd_t                    q_cmd
);
    import efr_pkg::*;

    typedef enum logic [2:0] {
        M_WAIT    = 3'b001,
        M_COLLECT = 3'b010,
        M_ESCAPED = 3'b100
    } mode_t;

    mode_t              mode_reg, mode_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [LIMIT_W-1:0] limit_reg;

    logic       accept;
    logic       is_ctrl;
    logic       full_store;
    logic [7:0] limit_ext;
    logic [7:0] depth_ext;
    logic [7:0] cap;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign is_ctrl  = (rx_byte == CH_SOH) || (rx_byte == CH_EOT) || (rx_byte == CH_ESC);

    // Capacity is the programmed limit, clamped to the store depth.
    assign limit_ext  = 8'(limit_reg);
    assign depth_ext  = 8'(STORE_DEPTH);
    assign cap        = (limit_ext > depth_ext) ? depth_ext : limit_ext;
    assign full_store = 8'(fill_reg) >= cap;

    // Frame limit register.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_W'(LIMIT_RESET);
        end
        else if (cfg_wr)
        begin
            limit_reg <= cfg_data;
        end
    end

    // Mode and fill level.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            mode_reg <= M_WAIT;
            fill_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            fill_reg <= fill_next;
        end
    end

    // Byte classification and command generation.
    always_comb begin
        logic do_push;
        do_push    = 1'b0;
        mode_next  = mode_reg;
        fill_next  = fill_reg;
        q_push     = 1'b0;
        q_cmd.op    = CMD_STORE;
        q_cmd.data  = rx_byte;
        q_cmd.count = fill_reg;
        q_cmd.code  = ERR_SOH;

        if (accept)
        begin
            unique case (mode_reg)
                M_COLLECT:
                begin
                    if (rx_byte == CH_SOH)
                    begin
                        mode_next  = M_WAIT;
                        fill_next  = '0;
                        q_push     = 1'b1;
                        q_cmd.op   = CMD_ERROR;
                        q_cmd.code = ERR_SOH;
                    end
                    else if (rx_byte == CH_EOT)
                    begin
                        mode_next = M_WAIT;
                        fill_next = '0;
                        q_push    = 1'b1;
                        q_cmd.op  = CMD_DRAIN;
                    end
                    else if (rx_byte == CH_ESC)
                    begin
                        mode_next = M_ESCAPED;
                    end
                    else
                    begin
                        do_push = 1'b1;
                    end
                end
                M_ESCAPED:
                begin
                    if (is_ctrl)
                    begin
                        mode_next = M_COLLECT;
                        do_push   = 1'b1;
                    end
                    else
                    begin
                        fill_next  = '0;
                        q_push     = 1'b1;
                        q_cmd.op   = CMD_ERROR;
                        q_cmd.code = ERR_ESC;
                    end
                end
                default:
                begin
                    if (rx_byte == CH_SOH)
                    begin
                        mode_next = M_COLLECT;
                    end
                end
            endcase

            // Store push, or overflow when the store is at capacity.
            if (do_push)
            begin
                q_push = 1'b1;
                if (full_store)
                begin
                    fill_next  = '0;
                    q_cmd.op   = CMD_ERROR;
                    q_cmd.code = ERR_OVERFLOW;
                end
                else
                begin
                    fill_next = fill_reg + CNT_W'(1);
                    q_cmd.op  = CMD_STORE;
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/efr_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escaped frame receiver command queue
// Short FIFO of commands that decouples the parser from the drain engine.
// ----------------------------------------------------------------------------
module efr_cmd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire efr_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output efr_pkg::cmd_t      head
);
    import efr_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full      = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = slot_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk) begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/efr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escaped frame receiver drain engine
// Executes commands: writes the frame store, reports errors with the running
// error total, and reads a completed frame out one byte per result.
// ----------------------------------------------------------------------------
module efr_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire efr_pkg::cmd_t q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [1:0]         kind,
    output logic [7:0]         payload_byte,
    output logic               last,
    output logic [1:0]         fault_code,
    output logic [15:0]        error_total
);
    import efr_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_READ = 3'b010,
        B_EMIT = 3'b100
    } bstate_t;

    bstate_t          state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [15:0]      tally_reg, tally_next;
    logic [7:0]       rd_data_reg;
    logic [7:0]       store_mem [STORE_DEPTH];

    logic        mem_we;
    logic        out_free;
    logic        load;
    kind_t       load_kind;
    logic [7:0]  load_byte;
    logic        load_last;
    err_code_t   load_code;

    logic        out_valid_reg;
    kind_t       kind_reg;
    logic [7:0]  payload_byte_reg;
    logic        last_reg;
    err_code_t   fault_code_reg;
    logic [15:0] error_total_reg;

    assign out_free = !out_valid_reg || !out_stall;

    // Frame store with registered read.
    always_ff @(posedge clk) begin
        if (mem_we)
        begin
            store_mem[q_head.count[ADDR_W-1:0]] <= q_head.data;
        end
        rd_data_reg <= store_mem[idx_reg[ADDR_W-1:0]];
    end

    // Command execution sequencer.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        tally_next = tally_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        load       = 1'b0;
        load_kind  = KIND_PAYLOAD;
        load_byte  = 8'h00;
        load_last  = 1'b1;
        load_code  = ERR_SOH;

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_head.op)
                        CMD_STORE:
                        begin
                            mem_we = 1'b1;
                            q_pop  = 1'b1;
                        end
                        CMD_ERROR:
                        begin
                            if (out_free)
                            begin
                                q_pop      = 1'b1;
                                load       = 1'b1;
                                load_kind  = KIND_ERROR;
                                load_code  = q_head.code;
                                tally_next = tally_reg + 16'd1;
                            end
                        end
                        CMD_DRAIN:
                        begin
                            if (q_head.count == '0)
                            begin
                                if (out_free)
                                begin
                                    q_pop     = 1'b1;
                                    load      = 1'b1;
                                    load_kind = KIND_EMPTY;
                                end
                            end
                            else
                            begin
                                q_pop      = 1'b1;
                                cnt_next   = q_head.count;
                                idx_next   = '0;
                                state_next = B_READ;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            B_READ:
            begin
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    load      = 1'b1;
                    load_kind = KIND_PAYLOAD;
                    load_byte = rd_data_reg;
                    load_last = (idx_reg + CNT_W'(1)) == cnt_reg;
                    if (load_last)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = B_READ;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            tally_reg <= tally_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk) begin
        if (load)
        begin
            kind_reg         <= load_kind;
            payload_byte_reg <= load_byte;
            last_reg         <= load_last;
            fault_code_reg   <= load_code;
            error_total_reg  <= tally_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign payload_byte = payload_byte_reg;
    assign last         = last_reg;
    assign fault_code   = fault_code_reg;
    assign error_total  = error_total_reg;

endmodule
`default_nettype wire

// File: sv/escaped_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escaped frame receiver
// Deframes a byte-stuffed SOH/EOT/ESC link into payload, empty-frame and
// error results.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Data
//  in       in_valid / in_stall    rx_byte
//  cfg      cfg_valid / cfg_ready  frame_limit
//  out      out_valid / out_stall  kind, payload_byte, last, fault_code,
//                                  error_total
//
// The parser takes one byte per cycle while the two-entry command queue has
// room. The drain engine stores a byte or reports an error for each command, and
// reads a frame out through the store's registered read port, passing through
// a read state and an emit state for each payload byte.
// Reset is asynchronous; the frame store needs no clearing pass.
// A stalled output holds its result; a full queue stalls the input.
// ----------------------------------------------------------------------------
module escaped_frame_receiver (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [7:0]                  rx_byte,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [efr_pkg::LIMIT_W-1:0] frame_limit,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [1:0]                       kind,
    output logic [7:0]                       payload_byte,
    output logic                             last,
    output logic [1:0]                       fault_code,
    output logic [15:0]                      error_total
);
    import efr_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    cmd_t q_cmd;
    cmd_t q_head;

    // The limit register accepts a transfer at any time.
    assign cfg_ready = 1'b1;

    efr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .cfg_wr   (cfg_valid),
        .cfg_data (frame_limit),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    efr_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    efr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .payload_byte (payload_byte),
        .last         (last),
        .fault_code   (fault_code),
        .error_total  (error_total)
    );

endmodule
`default_nettype wire

// File: sv/efr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escaped frame receiver checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module efr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [1:0]  kind,
    input wire logic [7:0]  payload_byte,
    input wire logic        last,
    input wire logic [1:0]  fault_code,
    input wire logic [15:0] error_total
);
    import efr_pkg::*;

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // Error and empty-frame results are single results, so they close the run.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_ERROR || kind == KIND_EMPTY) |-> last)
        else $error("single result without last mark");

    // Non-payload results carry a zero byte; non-error results a zero code.
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_ERROR || kind == KIND_EMPTY) |-> payload_byte == 8'h00)
        else $error("nonzero byte on a non-payload result");

    a_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_PAYLOAD || kind == KIND_EMPTY) |-> fault_code == 2'd0)
        else $error("nonzero error code on a non-error result");

    // The error total only changes on an error result.
    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall ##1 out_valid && kind != KIND_ERROR
        |-> error_total == $past(error_total))
        else $error("error total moved without an error");

endmodule

bind escaped_frame_receiver efr_checker u_efr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .last         (last),
    .fault_code   (fault_code),
    .error_total  (error_total)
);
`default_nettype wire
